// ===== sv/word_garbage_classifier_defines.svh =====
// Assertion macros for the word garbage classifier.
// Included by the top level; no other dependencies.
`ifndef WORD_GARBAGE_CLASSIFIER_DEFINES_SVH
`define WORD_GARBAGE_CLASSIFIER_DEFINES_SVH
`ifndef SYNTHESIS
`define WGC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define WGC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define WGC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define WGC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== sv/wgc_pkg.sv =====
// Shared types and codes for the word garbage classifier.
// No dependencies; used by the configuration interface and the top level.
`timescale 1ns / 1ps
package wgc_pkg;

	// Character classes
	localparam logic [2:0] CLS_UPPER = 3'd0;
	localparam logic [2:0] CLS_LOWER = 3'd1;
	localparam logic [2:0] CLS_DIGIT = 3'd2;
	localparam logic [2:0] CLS_SPACE = 3'd3;
	localparam logic [2:0] CLS_OTHER = 3'd4;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_LEAVE_OK     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_LIMIT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_OK    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LOWER_LIMIT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LIMIT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNT_NUM    = 3'd5;

	// Grading thresholds
	localparam int NEVER_MIN_LEN = 4;
	localparam int DODGY_LIMIT   = 5;
	localparam int SHORT_LEN     = 2;
	localparam int LEN_OUT_W     = 8;

	typedef enum logic [1:0] {
		GRADE_OK       = 2'd0,
		GRADE_DODGY    = 2'd1,
		GRADE_TERRIBLE = 2'd2,
		GRADE_NEVER    = 2'd3
	} grade_t;

endpackage

// ===== sv/wgc_if.sv =====
// Valid/ready channel interfaces of the word garbage classifier.
// Depends on wgc_pkg for the configuration port widths.
`timescale 1ns / 1ps
interface wgc_char_if #(parameter int CODE_BITS = 16);
	logic                 valid;
	logic                 ready;
	logic [2:0]           char_class;
	logic [CODE_BITS-1:0] char_code;
	logic                 empty_word;
	logic                 word_end;
	logic                 dictionary_permuter;
	logic                 acceptable_string;
	logic                 safe_dictionary_word;

	modport source (output valid, char_class, char_code, empty_word, word_end,
		dictionary_permuter, acceptable_string, safe_dictionary_word, input ready);
	modport sink (input valid, char_class, char_code, empty_word, word_end,
		dictionary_permuter, acceptable_string, safe_dictionary_word, output ready);
endinterface

interface wgc_grade_if;
	logic       valid;
	logic       ready;
	logic [1:0] garbage_grade;
	logic [7:0] word_length;

	modport source (output valid, garbage_grade, word_length, input ready);
	modport sink (input valid, garbage_grade, word_length, output ready);
endinterface

interface wgc_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [wgc_pkg::CFG_IDX_W-1:0]  index;
	logic [wgc_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/word_garbage_classifier.sv =====
// Word garbage classifier: one classified character per transaction on chars,
// one grade per word on grades. A new character is taken every cycle unless the
// grading stage is full and the output is stalled; the grade of a word passes
// through one register for the settled word figures, then one output register.
// The rate is set by the update of the run state and counters. Configuration
// writes on cfg are taken at any time and must only be made while idle.
// Depends on wgc_pkg, the interfaces in wgc_if.sv and the assertion macros.
`timescale 1ns / 1ps
`include "word_garbage_classifier_defines.svh"
module word_garbage_classifier #(
	parameter int MAX_WORD_LEN = 255,
	parameter int CODE_BITS    = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	wgc_char_if.sink    chars,
	wgc_grade_if.source grades,
	wgc_cfg_if.sink     cfg
);
	import wgc_pkg::*;

	localparam int CNT_W = $clog2(MAX_WORD_LEN + 1);
	localparam int SW    = CNT_W + 5;
	localparam logic [CNT_W-1:0] MAX_L = CNT_W'(MAX_WORD_LEN);
	localparam logic [CNT_W-1:0] ONE_L = CNT_W'(1);

	typedef enum logic [2:0] {
		ST_JUNK = 3'd0,
		ST_FU   = 3'd1,
		ST_FL   = 3'd2,
		ST_FN   = 3'd3,
		ST_SU   = 3'd4,
		ST_SL   = 3'd5,
		ST_SN   = 3'd6
	} run_state_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v >= MAX_L) ? MAX_L : v + ONE_L;
	endfunction

	// Configuration
	logic       leave_ok_q, accept_ok_q, count_num_q;
	logic [7:0] repeat_limit_q, lower_limit_q, upper_limit_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leave_ok_q     <= 1'b1;
			repeat_limit_q <= 8'd3;
			accept_ok_q    <= 1'b1;
			lower_limit_q  <= 8'd4;
			upper_limit_q  <= 8'd4;
			count_num_q    <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_LEAVE_OK:     leave_ok_q     <= cfg.data[0];
				CFG_REPEAT_LIMIT: repeat_limit_q <= cfg.data;
				CFG_ACCEPT_OK:    accept_ok_q    <= cfg.data[0];
				CFG_LOWER_LIMIT:  lower_limit_q  <= cfg.data;
				CFG_UPPER_LIMIT:  upper_limit_q  <= cfg.data;
				CFG_COUNT_NUM:    count_num_q    <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Word state
	run_state_t           state_q, n_state;
	logic [CNT_W-1:0]     char_total_q, lone_digits_q, lone_letters_q, bad_chars_q;
	logic [CNT_W-1:0]     reject_spaces_q, repeat_run_q, repeat_longest_q;
	logic [CNT_W-1:0]     lower_run_q, lower_longest_q, upper_run_q, upper_longest_q;
	logic [CNT_W-1:0]     letter_total_q, digit_total_q;
	logic [CODE_BITS-1:0] prev_letter_q;
	logic                 prev_valid_q;

	logic [CNT_W-1:0]     n_total, n_lone_d, n_lone_a, n_bad, n_rejs, n_rep_run, n_rep_long;
	logic [CNT_W-1:0]     n_low_run, n_low_long, n_up_run, n_up_long, n_letters, n_digits;
	logic [CODE_BITS-1:0] n_prev;
	logic                 n_prev_valid;

	logic                 is_upper, in_run;
	run_state_t           st_first, st_later;
	logic [CNT_W-1:0]     run_cur, long_cur, run_n, long_n, rep_n;

	always_comb begin
		n_state      = state_q;
		n_total      = char_total_q;
		n_lone_d     = lone_digits_q;
		n_lone_a     = lone_letters_q;
		n_bad        = bad_chars_q;
		n_rejs       = reject_spaces_q;
		n_rep_run    = repeat_run_q;
		n_rep_long   = repeat_longest_q;
		n_low_run    = lower_run_q;
		n_low_long   = lower_longest_q;
		n_up_run     = upper_run_q;
		n_up_long    = upper_longest_q;
		n_letters    = letter_total_q;
		n_digits     = digit_total_q;
		n_prev       = prev_letter_q;
		n_prev_valid = prev_valid_q;

		is_upper = (chars.char_class == CLS_UPPER);
		st_first = is_upper ? ST_FU : ST_FL;
		st_later = is_upper ? ST_SU : ST_SL;
		run_cur  = is_upper ? upper_run_q : lower_run_q;
		long_cur = is_upper ? upper_longest_q : lower_longest_q;
		in_run   = (state_q == st_first) || (state_q == st_later);
		run_n    = in_run ? sat_inc(run_cur) : ONE_L;
		long_n   = (in_run && run_n > long_cur) ? run_n : long_cur;
		rep_n    = sat_inc(repeat_run_q);

		if (!chars.empty_word) begin
			n_total = sat_inc(char_total_q);
			case (chars.char_class) inside
				CLS_UPPER, CLS_LOWER: begin
					n_letters = sat_inc(letter_total_q);
					if (is_upper) begin
						n_up_run  = run_n;
						n_up_long = long_n;
					end else begin
						n_low_run  = run_n;
						n_low_long = long_n;
					end
					if (in_run) begin
						n_state = st_later;
						if (prev_valid_q && prev_letter_q == chars.char_code) begin
							n_rep_run = rep_n;
							if (rep_n > repeat_longest_q)
								n_rep_long = rep_n;
						end else begin
							n_prev       = chars.char_code;
							n_prev_valid = 1'b1;
							n_rep_run    = ONE_L;
						end
					end else begin
						if (state_q == ST_FN)
							n_lone_d = sat_inc(lone_digits_q);
						n_state      = st_first;
						n_prev       = chars.char_code;
						n_prev_valid = 1'b1;
						n_rep_run    = ONE_L;
					end
				end
				CLS_DIGIT: begin
					n_digits = sat_inc(digit_total_q);
					if (state_q == ST_FN || state_q == ST_SN) begin
						n_state = ST_SN;
					end else begin
						if (state_q == ST_FU || state_q == ST_FL)
							n_lone_a = sat_inc(lone_letters_q);
						n_state = ST_FN;
					end
				end
				default: begin
					// space rejects and anything else end the run
					if (chars.char_class == CLS_SPACE)
						n_rejs = sat_inc(reject_spaces_q);
					else
						n_bad = sat_inc(bad_chars_q);
					if (state_q == ST_FN)
						n_lone_d = sat_inc(lone_digits_q);
					else if (state_q == ST_FU || state_q == ST_FL)
						n_lone_a = sat_inc(lone_letters_q);
					n_state = ST_JUNK;
				end
			endcase
		end
	end

	// Pipeline control
	logic s1_valid_s1, out_valid_q, s1_adv, in_acc;

	assign s1_adv      = s1_valid_s1 && (!out_valid_q || grades.ready);
	assign chars.ready = !s1_valid_s1 || s1_adv;
	assign in_acc      = chars.valid && chars.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_JUNK;
			char_total_q     <= '0;
			lone_digits_q    <= '0;
			lone_letters_q   <= '0;
			bad_chars_q      <= '0;
			reject_spaces_q  <= '0;
			repeat_run_q     <= '0;
			repeat_longest_q <= '0;
			lower_run_q      <= '0;
			lower_longest_q  <= '0;
			upper_run_q      <= '0;
			upper_longest_q  <= '0;
			letter_total_q   <= '0;
			digit_total_q    <= '0;
			prev_letter_q    <= '0;
			prev_valid_q     <= 1'b0;
		end else if (in_acc) begin
			if (chars.word_end) begin
				// clear for the next word
				state_q          <= ST_JUNK;
				char_total_q     <= '0;
				lone_digits_q    <= '0;
				lone_letters_q   <= '0;
				bad_chars_q      <= '0;
				reject_spaces_q  <= '0;
				repeat_run_q     <= '0;
				repeat_longest_q <= '0;
				lower_run_q      <= '0;
				lower_longest_q  <= '0;
				upper_run_q      <= '0;
				upper_longest_q  <= '0;
				letter_total_q   <= '0;
				digit_total_q    <= '0;
				prev_letter_q    <= '0;
				prev_valid_q     <= 1'b0;
			end else begin
				state_q          <= n_state;
				char_total_q     <= n_total;
				lone_digits_q    <= n_lone_d;
				lone_letters_q   <= n_lone_a;
				bad_chars_q      <= n_bad;
				reject_spaces_q  <= n_rejs;
				repeat_run_q     <= n_rep_run;
				repeat_longest_q <= n_rep_long;
				lower_run_q      <= n_low_run;
				lower_longest_q  <= n_low_long;
				upper_run_q      <= n_up_run;
				upper_longest_q  <= n_up_long;
				letter_total_q   <= n_letters;
				digit_total_q    <= n_digits;
				prev_letter_q    <= n_prev;
				prev_valid_q     <= n_prev_valid;
			end
		end
	end

	// Stage 1: settled word figures
	logic [CNT_W-1:0] len_s1, iso_d_s1, iso_a_s1, bad_s1, rejs_s1;
	logic [CNT_W-1:0] letters_s1, digits_s1, rep_long_s1, low_long_s1, up_long_s1;
	logic             perm_s1, accept_s1, safe_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (in_acc && chars.word_end) begin
			s1_valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && chars.word_end) begin
			len_s1      <= n_total;
			// an open first-of-run character counts as isolated
			iso_d_s1    <= (n_state == ST_FN) ? sat_inc(n_lone_d) : n_lone_d;
			iso_a_s1    <= (n_state == ST_FU || n_state == ST_FL) ? sat_inc(n_lone_a)
				: n_lone_a;
			bad_s1      <= n_bad;
			rejs_s1     <= n_rejs;
			letters_s1  <= n_letters;
			digits_s1   <= n_digits;
			rep_long_s1 <= n_rep_long;
			low_long_s1 <= n_low_long;
			up_long_s1  <= n_up_long;
			perm_s1     <= chars.dictionary_permuter;
			accept_s1   <= chars.acceptable_string;
			safe_s1     <= chars.safe_dictionary_word;
		end
	end

	// Stage 2: grading
	logic signed [SW-1:0] len, iso_d, iso_a, bad, rejs, alpha, good_chars, dodgy, dodgy_short;
	logic signed [SW-1:0] rep_long, low_long, up_long, rep_lim, low_lim, up_lim;
	grade_t               grade_c;
	logic [LEN_OUT_W-1:0] len_out_c;

	always_comb begin
		len      = SW'(len_s1);
		iso_d    = SW'(iso_d_s1);
		iso_a    = SW'(iso_a_s1);
		bad      = SW'(bad_s1);
		rejs     = SW'(rejs_s1);
		rep_long = SW'(rep_long_s1);
		low_long = SW'(low_long_s1);
		up_long  = SW'(up_long_s1);
		rep_lim  = SW'(repeat_limit_q);
		low_lim  = SW'(lower_limit_q);
		up_lim   = SW'(upper_limit_q);
		alpha    = count_num_q ? SW'(letters_s1) + SW'(digits_s1) - iso_d : SW'(letters_s1);
		good_chars = len - bad - iso_d - iso_a - rejs;
		dodgy    = (rejs <<< 1) + bad + iso_d + iso_a;
		dodgy_short = (rejs <<< 1) + bad;

		if (leave_ok_q && len >= SW'(NEVER_MIN_LEN) && ((alpha - iso_a) <<< 1) > len
				&& rep_long < rep_lim
				&& ((accept_ok_q && accept_s1) || low_long > low_lim || up_long > up_lim)) begin
			grade_c = GRADE_NEVER;
		end else if (len > SW'(1) && rejs == '0 && (perm_s1 || accept_s1 || safe_s1)) begin
			grade_c = GRADE_OK;
		end else if (bad == '0 && rejs == '0
				&& (len > iso_d + iso_a || len <= SW'(SHORT_LEN))) begin
			grade_c = GRADE_OK;
		end else if (rejs > good_chars || (rejs > '0 && ((bad + rejs) <<< 1) > len)) begin
			grade_c = GRADE_TERRIBLE;
		end else if (len > SW'(NEVER_MIN_LEN)) begin
			grade_c = (dodgy > SW'(DODGY_LIMIT) || (dodgy <<< 1) > len) ? GRADE_DODGY
				: GRADE_OK;
		end else if (((len == SW'(4) || len == SW'(3)) && dodgy_short > SW'(2))
				|| dodgy_short >= len) begin
			grade_c = GRADE_DODGY;
		end else begin
			grade_c = GRADE_OK;
		end

		len_out_c = (len >= SW'(255)) ? 8'hFF : len[LEN_OUT_W-1:0];
	end

	// Output register
	grade_t               grade_q;
	logic [LEN_OUT_W-1:0] word_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (grades.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			grade_q       <= grade_c;
			word_length_q <= len_out_c;
		end
	end

	assign grades.valid         = out_valid_q;
	assign grades.garbage_grade = grade_q;
	assign grades.word_length   = word_length_q;

	`WGC_ASSERT_NXT(a_end_loads_s1, clk, arst_n, in_acc && chars.word_end, s1_valid_s1,
		"last character did not load the grading stage")
	`WGC_ASSERT_NXT(a_end_clears, clk, arst_n, in_acc && chars.word_end,
		char_total_q == '0 && state_q == ST_JUNK && !prev_valid_q,
		"word state not cleared after last character")
	`WGC_ASSERT_IMP(a_lone_bound, clk, arst_n, 1'b1,
		lone_digits_q <= char_total_q && lone_letters_q <= char_total_q,
		"isolated count exceeds character count")

endmodule
